/* rtl/apidx_pkg.sv */
// Package for the adaptive palette indexer.
// Holds field widths, default sizing and the controller/datapath command and status types.
// No dependencies.
package apidx_pkg;

    // Fixed field widths of the item and result beats.
    localparam int COLOR_W = 24;
    localparam int INDEX_W = 8;
    localparam int USED_W  = 9;

    // Default palette depth.
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;    // capture the item and apply restart
        logic scan;     // issue the next palette read
        logic resolve;  // settle hit, append or overflow
        logic publish;  // load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ovf;        // overflow flag is set
        logic hit;        // the compared entry matches the color
        logic exhausted;  // all filled entries compared without a match
        logic out_free;   // output register can take a new beat
    } t_dp_status;

endpackage

/* rtl/apidx_ctrl.sv */
// Controller state machine of the adaptive palette indexer.
// Sequences capture, palette scan, resolve and output; depends on apidx_pkg.
module apidx_ctrl
    import apidx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_status.ovf || i_status.hit || i_status.exhausted) begin
                    o_cmd.resolve = 1'b1;
                    n_state       = ST_RESULT;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            ST_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A new item beat is taken only between items.
    assign o_ready = (r_state == ST_IDLE);

endmodule

/* rtl/apidx_dp.sv */
// Datapath of the adaptive palette indexer: palette memory, fill count,
// overflow flag, scan pointer, comparator and output register; depends on apidx_pkg.
module apidx_dp
    import apidx_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic [COLOR_W-1:0] i_pixel_color,
    input  logic               i_restart,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [INDEX_W-1:0] o_palette_index,
    output logic               o_added_entry,
    output logic               o_overflowed,
    output logic [USED_W-1:0]  o_colors_used
);

    localparam int IW = $clog2(PALETTE_ENTRIES);
    localparam int CW = $clog2(PALETTE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(PALETTE_ENTRIES);

    // Palette storage, written only by appends.
    logic [COLOR_W-1:0] r_mem [PALETTE_ENTRIES];

    logic [COLOR_W-1:0] r_color;
    logic [COLOR_W-1:0] r_rdata;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_addr;
    logic [IW-1:0]      r_cmp_idx;
    logic               r_cmp_valid;
    logic               r_ovf;
    logic [IW-1:0]      r_res_idx;
    logic               r_res_add;
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_idx;
    logic               r_out_add;
    logic               r_out_ovf;
    logic [USED_W-1:0]  r_out_used;

    logic rd_en;
    logic hit;
    logic exhausted;
    logic full;
    logic do_append;
    logic out_free;

    // Scan and resolve decisions.
    assign rd_en     = i_cmd.scan && (r_addr < r_count);
    assign hit       = r_cmp_valid && (r_rdata == r_color);
    assign exhausted = !r_cmp_valid && (r_addr == r_count);
    assign full      = (r_count == FULL);
    assign do_append = i_cmd.resolve && !r_ovf && !hit && !full;
    assign out_free  = !r_out_valid || i_ready;

    assign o_status.ovf       = r_ovf;
    assign o_status.hit       = hit;
    assign o_status.exhausted = exhausted;
    assign o_status.out_free  = out_free;

    // Memory write on append and registered read during the scan.
    always_ff @(posedge i_clk) begin
        if (do_append) begin
            r_mem[r_count[IW-1:0]] <= r_color;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_addr[IW-1:0]];
        end
    end

    // Control state: fill count, overflow, compare valid, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_valid <= rd_en;
            if (i_cmd.start && i_restart) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (do_append) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.resolve && !r_ovf && !hit && full) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item capture, scan pointer, result and output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_color <= i_pixel_color;
            r_addr  <= '0;
        end else if (rd_en) begin
            r_addr <= r_addr + 1'b1;
        end
        if (rd_en) begin
            r_cmp_idx <= r_addr[IW-1:0];
        end
        if (i_cmd.resolve) begin
            if (r_ovf) begin
                r_res_idx <= '0;
                r_res_add <= 1'b0;
            end else if (hit) begin
                r_res_idx <= r_cmp_idx;
                r_res_add <= 1'b0;
            end else if (!full) begin
                r_res_idx <= r_count[IW-1:0];
                r_res_add <= 1'b1;
            end else begin
                r_res_idx <= '0;
                r_res_add <= 1'b0;
            end
        end
        if (i_cmd.publish) begin
            r_out_idx  <= INDEX_W'(r_res_idx);
            r_out_add  <= r_res_add;
            r_out_ovf  <= r_ovf;
            r_out_used <= USED_W'(r_count);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_palette_index = r_out_idx;
    assign o_added_entry   = r_out_add;
    assign o_overflowed    = r_out_ovf;
    assign o_colors_used   = r_out_used;

endmodule

/* rtl/adaptive_palette_indexer.sv */
// Adaptive palette indexer: maps 24-bit colors to palette indices built on the fly.
// Throughput: one item per search, set by the single read port of the palette memory
// scanned one entry per cycle.
// Reset (synchronous, active low) empties the palette and clears the overflow flag.
// Depends on apidx_pkg, apidx_ctrl and apidx_dp.
module adaptive_palette_indexer
    import apidx_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COLOR_W-1:0] i_pixel_color,
    input  logic               i_restart,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [INDEX_W-1:0] o_palette_index,
    output logic               o_added_entry,
    output logic               o_overflowed,
    output logic [USED_W-1:0]  o_colors_used
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer.
    apidx_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Palette storage and search datapath.
    apidx_dp #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_pixel_color   (i_pixel_color),
        .i_restart       (i_restart),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_palette_index (o_palette_index),
        .o_added_entry   (o_added_entry),
        .o_overflowed    (o_overflowed),
        .o_colors_used   (o_colors_used)
    );

endmodule

/* rtl/apidx_checker.sv */
// Port-level checks for the adaptive palette indexer, bound to the top level.
// Depends on apidx_pkg and adaptive_palette_indexer.
module apidx_checker
    import apidx_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [INDEX_W-1:0] o_palette_index,
    input logic               o_added_entry,
    input logic               o_overflowed,
    input logic [USED_W-1:0]  o_colors_used
);

    localparam logic [USED_W:0] CAP = (USED_W+1)'(PALETTE_ENTRIES);
    localparam bit WIDE = (PALETTE_ENTRIES >= (1 << USED_W));

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_palette_index)
            && $stable(o_added_entry) && $stable(o_overflowed) && $stable(o_colors_used))
        else $error("result beat changed while stalled");

    // The fill count never exceeds the palette depth.
    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> WIDE || ({1'b0, o_colors_used} <= CAP))
        else $error("colors_used beyond palette depth");

    // With overflow set, no entry is added and the index is zero.
    a_ovf_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflowed |-> !o_added_entry && (o_palette_index == '0))
        else $error("overflowed result with nonzero index or append");

    // An appended color lands at the last filled entry.
    a_append_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_added_entry |-> o_palette_index == INDEX_W'(o_colors_used - 1'b1))
        else $error("appended index does not match fill count");

endmodule

bind adaptive_palette_indexer apidx_checker #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
) u_apidx_checker (.*);

/* dv/adaptive_palette_indexer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the adaptive palette indexer: a clocked driver, a clocked
// monitor and a palette predictor that tracks fill count and the sticky overflow flag.
// Depends on apidx_pkg and the adaptive_palette_indexer RTL.
module adaptive_palette_indexer_tb;
    import apidx_pkg::*;

    localparam int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF;
    localparam int CLK_PERIOD      = 10;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int PHASE_BEATS     = 50;
    localparam int RANDOM_BEATS    = 600;
    localparam int DRAIN_CYCLES    = 300;
    localparam int MAX_REPORTS     = 10;

    // Idling patterns, stepped through as input beats are accepted.
    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_phase;

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic               restart;
        bit                 drain_first;  // wait for all results before offering
        bit                 hold_rx;      // starts a long receiver hold-off once accepted
    } t_pixel_item;

    typedef struct packed {
        logic [INDEX_W-1:0] pal_index;
        logic               added;
        logic               ovf;
        logic [USED_W-1:0]  used;
    } t_palette_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [COLOR_W-1:0] i_pixel_color = '0;
    logic               i_restart = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [INDEX_W-1:0] o_palette_index;
    logic               o_added_entry;
    logic               o_overflowed;
    logic [USED_W-1:0]  o_colors_used;

    t_pixel_item     pending_pixels[$];
    t_palette_result expected_results[$];

    // Predicted palette contents.
    logic [COLOR_W-1:0] palette_colors[PALETTE_ENTRIES];
    int                 palette_fill = 0;
    bit                 palette_overflow = 1'b0;

    int accepted_cnt = 0;
    int mismatch_cnt = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    bit cur_hold = 1'b0;

    adaptive_palette_indexer #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pixel_color  (i_pixel_color),
        .i_restart      (i_restart),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_palette_index(o_palette_index),
        .o_added_entry  (o_added_entry),
        .o_overflowed   (o_overflowed),
        .o_colors_used  (o_colors_used)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Look the color up in the predicted palette, appending it on a miss while room is left.
    function automatic t_palette_result lookup_color(input logic [COLOR_W-1:0] color,
                                                     input logic restart);
        t_palette_result res;
        bit              hit;
        int              k;
        res = '0;
        hit = 1'b0;
        if (restart) begin
            palette_fill     = 0;
            palette_overflow = 1'b0;
        end
        if (!palette_overflow) begin
            for (k = 0; k < palette_fill && !hit; k++) begin
                if (palette_colors[k] == color) begin
                    hit           = 1'b1;
                    res.pal_index = k[INDEX_W-1:0];
                end
            end
            if (!hit) begin
                if (palette_fill < PALETTE_ENTRIES) begin
                    res.pal_index                = palette_fill[INDEX_W-1:0];
                    palette_colors[palette_fill] = color;
                    palette_fill++;
                    res.added = 1'b1;
                end else begin
                    palette_overflow = 1'b1;
                end
            end
        end
        res.ovf  = palette_overflow;
        res.used = palette_fill[USED_W-1:0];
        return res;
    endfunction

    function automatic t_idle_phase current_phase();
        return t_idle_phase'((accepted_cnt / PHASE_BEATS) % 4);
    endfunction

    function automatic bit sender_idles();
        case (current_phase())
            IDLE_SEND: return $urandom_range(0, 99) < 75;
            IDLE_BOTH: return $urandom_range(0, 99) < 20;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (current_phase())
            IDLE_RECV: return $urandom_range(0, 99) < 75;
            IDLE_BOTH: return $urandom_range(0, 99) < 20;
            default:   return 1'b0;
        endcase
    endfunction

    task automatic queue_pixel(input logic [COLOR_W-1:0] color, input logic restart,
                               input bit drain_first = 1'b0, input bit hold_rx = 1'b0);
        t_pixel_item item;
        item.color       = color;
        item.restart     = restart;
        item.drain_first = drain_first;
        item.hold_rx     = hold_rx;
        pending_pixels.push_back(item);
    endtask

    // Driver: predicts each accepted beat and offers the next pending pixel.
    always @(posedge i_clk) begin : drive_pixels
        t_pixel_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_results.push_back(lookup_color(i_pixel_color, i_restart));
                accepted_cnt <= accepted_cnt + 1;
                if (cur_hold) begin
                    hold_req <= hold_req + 1;
                end
            end
            if (!i_valid || o_ready) begin
                if (pending_pixels.size() != 0 && !sender_idles() &&
                    (!pending_pixels[0].drain_first || expected_results.size() == 0)) begin
                    nxt = pending_pixels.pop_front();
                    i_valid       <= 1'b1;
                    i_pixel_color <= nxt.color;
                    i_restart     <= nxt.restart;
                    cur_hold      <= nxt.hold_rx;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request so the block backs up.
    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= RX_HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= !receiver_stalls();
        end
    end

    // Monitor: each result beat is checked against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_palette_result want;
        t_palette_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_palette_index, o_added_entry, o_overflowed, o_colors_used};
            if (expected_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS) begin
                    $display("[%0t] unexpected result beat: index %0d added %0b %s",
                             $realtime, got.pal_index, got.added,
                             $sformatf("ovf %0b used %0d", got.ovf, got.used));
                end
            end else begin
                want = expected_results.pop_front();
                if (got.pal_index !== want.pal_index || got.added !== want.added ||
                    got.ovf !== want.ovf || got.used !== want.used) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("[%0t] mismatch: index %0d/%0d added %0b/%0b %s",
                                 $realtime, got.pal_index, want.pal_index, got.added,
                                 want.added,
                                 $sformatf("ovf %0b/%0b used %0d/%0d (got/exp)",
                                           got.ovf, want.ovf, got.used, want.used));
                    end
                end
            end
        end
    end

    // Stimulus, reset and final verdict.
    initial begin : run_test
        logic [COLOR_W-1:0] color_set[16];
        logic [COLOR_W-1:0] fill_colors[PALETTE_ENTRIES];
        logic [31:0]        r;
        int                 random_beats;
        int                 set_size;
        int                 n;
        int                 k;
        bit                 full_fill_done;

        // Directed: field extremes, hits, appends and restarts.
        queue_pixel(24'h000000, 1'b1);
        queue_pixel(24'hFFFFFF, 1'b0);
        queue_pixel(24'h000000, 1'b0);
        queue_pixel(24'hFFFFFF, 1'b0);
        queue_pixel(24'hAAAAAA, 1'b0);
        queue_pixel(24'h555555, 1'b0);
        queue_pixel(24'h555555, 1'b0);
        queue_pixel(24'h000001, 1'b0);
        queue_pixel(24'h800000, 1'b0);
        queue_pixel(24'hAAAAAB, 1'b0);
        queue_pixel(24'hAAAAAA, 1'b0);
        // Restart empties the table: old entries must not be matched again.
        queue_pixel(24'hFFFFFF, 1'b1);
        queue_pixel(24'h000000, 1'b0);
        queue_pixel(24'h555555, 1'b0);
        queue_pixel(24'h800000, 1'b0);
        queue_pixel(24'h000000, 1'b1);
        queue_pixel(24'h000000, 1'b1);
        queue_pixel(24'h123456, 1'b0, 1'b1);
        queue_pixel(24'h123456, 1'b0);
        queue_pixel(24'h654321, 1'b0, 1'b0, 1'b1);
        for (k = 0; k < 15; k++) begin
            queue_pixel(24'h654321 ^ k[COLOR_W-1:0], 1'b0);
        end

        // Random part: mostly small palettes, one full fill into overflow.
        random_beats   = 0;
        full_fill_done = 1'b0;
        while (random_beats < RANDOM_BEATS) begin
            if (random_beats >= 120 && !full_fill_done) begin
                // Fill every entry with distinct colors, then push past capacity.
                full_fill_done = 1'b1;
                for (k = 0; k < PALETTE_ENTRIES; k++) begin
                    r = $urandom;
                    fill_colors[k] = {r[15:0], k[7:0]};
                    queue_pixel(fill_colors[k], k == 0);
                end
                queue_pixel(fill_colors[PALETTE_ENTRIES-1], 1'b0);
                queue_pixel(fill_colors[0], 1'b0);
                queue_pixel(fill_colors[$urandom_range(1, PALETTE_ENTRIES - 2)], 1'b0);
                for (k = 0; k < 3; k++) begin
                    queue_pixel(COLOR_W'($urandom), 1'b0);
                end
                queue_pixel(fill_colors[7], 1'b0);
                queue_pixel(fill_colors[PALETTE_ENTRIES-1], 1'b0);
                queue_pixel(fill_colors[200], 1'b1, 1'b1);
                queue_pixel(fill_colors[7], 1'b0);
                queue_pixel(fill_colors[200], 1'b0);
                random_beats += PALETTE_ENTRIES + 11;
            end else if ($urandom_range(0, 9) == 0) begin
                // Noise with stray restarts.
                for (k = 0; k < 8; k++) begin
                    queue_pixel(COLOR_W'($urandom), $urandom_range(0, 9) == 0);
                end
                random_beats += 8;
            end else begin
                // Small palette: a set of colors and near misses, then mostly hits.
                set_size = $urandom_range(1, 16);
                for (k = 0; k < set_size; k++) begin
                    if (k != 0 && $urandom_range(0, 2) == 0) begin
                        color_set[k] = color_set[k-1] ^ (24'd1 << $urandom_range(0, 23));
                    end else begin
                        color_set[k] = COLOR_W'($urandom);
                    end
                end
                n = $urandom_range(5, 30);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        queue_pixel(COLOR_W'($urandom), 1'b0);
                    end else begin
                        queue_pixel(color_set[$urandom_range(0, set_size - 1)], k == 0,
                                    $urandom_range(0, 59) == 0, $urandom_range(0, 199) == 0);
                    end
                end
                random_beats += n;
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pixels.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* adaptive_palette_indexer.f */
rtl/apidx_pkg.sv
rtl/apidx_ctrl.sv
rtl/apidx_dp.sv
rtl/adaptive_palette_indexer.sv
rtl/apidx_checker.sv
dv/adaptive_palette_indexer_tb.sv
